>>> hdl/socks5_pkg.sv
`timescale 1ns / 1ps

package socks5_pkg;

  localparam int FUNC_W   = 2;
  localparam int KIND_W   = 3;
  localparam int VALUE_W  = 16;
  localparam int BYTE_W   = 8;
  localparam int AKIND_W  = 2;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 4;

  // func codes
  localparam logic [FUNC_W-1:0] FUNC_DATA  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_OPEN  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLOSE = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_REPLY   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ADDR    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DONE    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_PAYLOAD = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ABORT   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CLOSE   = 3'd5;

  // address kinds
  localparam logic [AKIND_W-1:0] AKIND_IPV4 = 2'd0;
  localparam logic [AKIND_W-1:0] AKIND_FQDN = 2'd1;
  localparam logic [AKIND_W-1:0] AKIND_IPV6 = 2'd2;

  // protocol bytes
  localparam logic [BYTE_W-1:0] SOCKS_VERSION = 8'd5;
  localparam logic [BYTE_W-1:0] ATYP_IPV4     = 8'd1;
  localparam logic [BYTE_W-1:0] ATYP_FQDN     = 8'd3;
  localparam logic [BYTE_W-1:0] ATYP_IPV6     = 8'd4;
  localparam logic [BYTE_W-1:0] CMD_CONNECT   = 8'd1;
  localparam logic [BYTE_W-1:0] CMD_ASSOCIATE = 8'd3;
  localparam logic [BYTE_W-1:0] IPV4_LEN      = 8'd4;
  localparam logic [BYTE_W-1:0] IPV6_LEN      = 8'd16;
  localparam logic [VALUE_W-1:0] REPLY_WORD   = 16'h0500;

  typedef struct packed {
    logic [AKIND_W-1:0] addr_kind;
    logic               use_udp;
    logic [BYTE_W-1:0]  addr_total;
    logic [BYTE_W-1:0]  addr_index;
    logic [VALUE_W-1:0] value;
  } res_data_t;

  typedef struct packed {
    logic              first_payload;
    logic [KIND_W-1:0] kind;
  } res_user_t;

endpackage

>>> hdl/socks5_handshake_parser.sv
// a result is registered and shows on out_ the cycle after its byte is accepted
// throughput: one transaction per cycle; in_tready is high while the result register
// is empty or being drained, so a byte is taken every cycle without output stalls
// reset: synchronous, active low; clears the parser state and the result valid,
// leaving the block idle awaiting a new connection
`timescale 1ns / 1ps

module socks5_handshake_parser (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [socks5_pkg::IN_DATA_W-1:0]   in_tdata,   // data_byte
  input  logic [socks5_pkg::FUNC_W-1:0]      in_tuser,   // func
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // value, addr_index, addr_total, use_udp, addr_kind, zero fill
  output logic [socks5_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [socks5_pkg::OUT_USER_W-1:0]  out_tuser   // kind, first_payload
);

  import socks5_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_GVER, PH_GCOUNT, PH_METHODS, PH_RVER, PH_RCMD, PH_RRSV,
    PH_ATYP, PH_DLEN, PH_ADDR, PH_PORTH, PH_PORTL, PH_PAYLOAD, PH_ABORTED
  } phase_t;

  localparam int PAD_W = OUT_DATA_W - $bits(res_data_t);

  phase_t             phase_r, phase_nxt;
  logic [BYTE_W-1:0]  remaining_r, remaining_nxt;
  logic [BYTE_W-1:0]  addr_pos_r, addr_pos_nxt;
  logic [BYTE_W-1:0]  addr_len_r, addr_len_nxt;
  logic               udp_r, udp_nxt;
  logic [AKIND_W-1:0] akind_r, akind_nxt;
  logic [BYTE_W-1:0]  port_hi_r, port_hi_nxt;
  logic               seen_r, seen_nxt;

  logic               out_valid_r;
  res_data_t          res_data_r, res_data;
  res_user_t          res_user_r, res_user;
  logic               res_valid;
  logic               in_acc;
  logic [BYTE_W-1:0]  b;
  logic [BYTE_W-1:0]  rem_dec;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign b         = in_tdata;
  assign rem_dec   = remaining_r - 8'd1;

  always_comb begin
    phase_nxt     = phase_r;
    remaining_nxt = remaining_r;
    addr_pos_nxt  = addr_pos_r;
    addr_len_nxt  = addr_len_r;
    udp_nxt       = udp_r;
    akind_nxt     = akind_r;
    port_hi_nxt   = port_hi_r;
    seen_nxt      = seen_r;
    res_valid     = 1'b0;
    res_data      = '0;
    res_user      = '0;

    if (in_acc) begin
      unique case (in_tuser) inside
        FUNC_OPEN, FUNC_CLOSE: begin
          phase_nxt     = (in_tuser == FUNC_OPEN) ? PH_GVER : PH_IDLE;
          remaining_nxt = '0;
          addr_pos_nxt  = '0;
          addr_len_nxt  = '0;
          udp_nxt       = 1'b0;
          akind_nxt     = '0;
          port_hi_nxt   = '0;
          seen_nxt      = 1'b0;
          if (in_tuser == FUNC_CLOSE && phase_r == PH_PAYLOAD) begin
            res_valid     = 1'b1;
            res_user.kind = KIND_CLOSE;
          end
        end
        FUNC_DATA: begin
          unique case (phase_r)
            PH_GVER: begin
              if (b != SOCKS_VERSION) res_valid = 1'b1;
              else phase_nxt = PH_GCOUNT;
            end
            PH_GCOUNT: begin
              if (b == '0) res_valid = 1'b1;
              else begin
                remaining_nxt = b;
                phase_nxt     = PH_METHODS;
              end
            end
            PH_METHODS: begin
              remaining_nxt = rem_dec;
              if (rem_dec == '0) begin
                phase_nxt      = PH_RVER;
                res_valid      = 1'b1;
                res_user.kind  = KIND_REPLY;
                res_data.value = REPLY_WORD;
              end
            end
            PH_RVER: begin
              if (b != SOCKS_VERSION) res_valid = 1'b1;
              else phase_nxt = PH_RCMD;
            end
            PH_RCMD: begin
              if (b == CMD_CONNECT || b == CMD_ASSOCIATE) begin
                udp_nxt   = (b == CMD_ASSOCIATE);
                phase_nxt = PH_RRSV;
              end else begin
                res_valid = 1'b1;
              end
            end
            PH_RRSV: phase_nxt = PH_ATYP;
            PH_ATYP: begin
              if (b == ATYP_IPV4 || b == ATYP_IPV6) begin
                akind_nxt     = (b == ATYP_IPV4) ? AKIND_IPV4 : AKIND_IPV6;
                addr_len_nxt  = (b == ATYP_IPV4) ? IPV4_LEN : IPV6_LEN;
                remaining_nxt = (b == ATYP_IPV4) ? IPV4_LEN : IPV6_LEN;
                addr_pos_nxt  = '0;
                phase_nxt     = PH_ADDR;
              end else if (b == ATYP_FQDN) begin
                akind_nxt = AKIND_FQDN;
                phase_nxt = PH_DLEN;
              end else begin
                res_valid = 1'b1;
              end
            end
            PH_DLEN: begin
              if (b == '0) res_valid = 1'b1;
              else begin
                addr_len_nxt  = b;
                remaining_nxt = b;
                addr_pos_nxt  = '0;
                phase_nxt     = PH_ADDR;
              end
            end
            PH_ADDR: begin
              res_valid           = 1'b1;
              res_user.kind       = KIND_ADDR;
              res_data.value      = {8'd0, b};
              res_data.addr_index = addr_pos_r;
              res_data.addr_total = addr_len_r;
              res_data.use_udp    = udp_r;
              res_data.addr_kind  = akind_r;
              addr_pos_nxt        = addr_pos_r + 8'd1;
              remaining_nxt       = rem_dec;
              if (rem_dec == '0) phase_nxt = PH_PORTH;
            end
            PH_PORTH: begin
              port_hi_nxt = b;
              phase_nxt   = PH_PORTL;
            end
            PH_PORTL: begin
              res_valid           = 1'b1;
              res_user.kind       = KIND_DONE;
              res_data.value      = {port_hi_r, b};
              res_data.addr_total = addr_len_r;
              res_data.use_udp    = udp_r;
              res_data.addr_kind  = akind_r;
              phase_nxt           = PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
              res_valid              = 1'b1;
              res_user.kind          = KIND_PAYLOAD;
              res_user.first_payload = !seen_r;
              res_data.value         = {8'd0, b};
              seen_nxt               = 1'b1;
            end
            default: ;
          endcase

          // failed field check: abort and drop the connection state
          if (res_valid && res_user.kind == KIND_REPLY && phase_r != PH_METHODS) begin
            res_user.kind = KIND_ABORT;
            phase_nxt     = PH_ABORTED;
            remaining_nxt = '0;
            addr_pos_nxt  = '0;
            addr_len_nxt  = '0;
            udp_nxt       = 1'b0;
            akind_nxt     = '0;
            port_hi_nxt   = '0;
            seen_nxt      = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      remaining_r <= '0;
      addr_pos_r  <= '0;
      addr_len_r  <= '0;
      udp_r       <= 1'b0;
      akind_r     <= '0;
      port_hi_r   <= '0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      remaining_r <= remaining_nxt;
      addr_pos_r  <= addr_pos_nxt;
      addr_len_r  <= addr_len_nxt;
      udp_r       <= udp_nxt;
      akind_r     <= akind_nxt;
      port_hi_r   <= port_hi_nxt;
      seen_r      <= seen_nxt;
      if (in_tready) begin
        out_valid_r <= in_acc && res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      res_data_r <= res_data;
      res_user_r <= res_user;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, res_data_r};
  assign out_tuser  = res_user_r;

`ifndef SYNTHESIS
  a_close_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tuser == FUNC_CLOSE |=> phase_r == PH_IDLE)
    else $error("phase not idle after close");

  a_addr_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_user_r.kind == KIND_ADDR |->
      res_data_r.addr_index < res_data_r.addr_total)
    else $error("address index beyond address length");

  a_first_only_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_user_r.first_payload |-> res_user_r.kind == KIND_PAYLOAD)
    else $error("first payload flag on non-payload result");
`endif

endmodule
